/* src/bsgd_pkg.sv */
`timescale 1ns / 1ps
package bsgd_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 15;

  // reset coefficients as given at 15 fraction bits, rescaled to the build
  localparam int  BASE_FRAC_BITS   = 15;
  localparam longint LOW_ALPHA_BASE  = 86;
  localparam longint HIGH_ALPHA_BASE = 30000;
  localparam longint SMOOTH_BASE     = 32597;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_ALPHA  = 2'd0,
    REG_HIGH_ALPHA = 2'd1,
    REG_SMOOTH     = 2'd2,
    REG_MIX        = 2'd3
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_LOW_MUL  = 10'b00_0000_0010,
    ST_LOW_ADD  = 10'b00_0000_0100,
    ST_HIGH_MUL = 10'b00_0000_1000,
    ST_HIGH_ADD = 10'b00_0001_0000,
    ST_BAND_MUL = 10'b00_0010_0000,
    ST_BAND_ADD = 10'b00_0100_0000,
    ST_MIX_MUL  = 10'b00_1000_0000,
    ST_MIX_ADD  = 10'b01_0000_0000,
    ST_DONE     = 10'b10_0000_0000
  } lane_state_t;

endpackage

/* src/band_split_gain_ducker_top.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// frame    | in        | frame_valid/frame_stall | left_sample, right_sample, target_gain
// result   | out       | result_valid/result_stall | left_out, right_out, applied_gain
// cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// a new request is taken only once the last one has merged: frame_stall stays high through
// the four multiply and round steps that each channel lane runs on its single multiplier,
// and through the merge into the result register
// result_valid rises with the merge, once both lanes are done and the output register is free
// the next request is taken while a finished result still waits on result_stall
// rst is synchronous: gain returns to unity, filter levels to zero, registers to defaults
module band_split_gain_ducker_top #(
  parameter int SAMPLE_BITS    = bsgd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bsgd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_valid,
  output logic                                frame_stall,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample,
  input  logic [COEF_FRAC_BITS:0]             target_gain,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       left_out,
  output logic signed [SAMPLE_BITS-1:0]       right_out,
  output logic [COEF_FRAC_BITS:0]             applied_gain,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsgd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_FRAC_BITS:0]             cfg_data
);

  import bsgd_pkg::*;

  localparam int CW  = COEF_FRAC_BITS;
  localparam int GBW = COEF_FRAC_BITS + 1;
  localparam logic [GBW-1:0] ONE = GBW'(1) << COEF_FRAC_BITS;
  localparam logic [CW-1:0] LOW_ALPHA_RST =
    CW'(LOW_ALPHA_BASE * (longint'(1) << CW) / (longint'(1) << BASE_FRAC_BITS));
  localparam logic [CW-1:0] HIGH_ALPHA_RST =
    CW'(HIGH_ALPHA_BASE * (longint'(1) << CW) / (longint'(1) << BASE_FRAC_BITS));
  localparam logic [CW-1:0] SMOOTH_RST =
    CW'(SMOOTH_BASE * (longint'(1) << CW) / (longint'(1) << BASE_FRAC_BITS));

  logic [CW-1:0]  low_alpha;
  logic [CW-1:0]  high_alpha;
  logic [CW-1:0]  smooth_coefficient;
  logic [GBW-1:0] mix_amount;
  logic [GBW-1:0] mix_c;

  logic           busy;
  logic           start;
  logic           merge;
  logic [1:0]     lane_done;
  logic signed [SAMPLE_BITS-1:0] lane_result [2];
  logic [GBW-1:0] gain;

  assign cfg_ready   = 1'b1;
  assign frame_stall = busy;
  assign start       = frame_valid && !busy;
  assign merge       = busy && lane_done[0] && lane_done[1] && (!result_valid || !result_stall);
  assign mix_c       = (mix_amount > ONE) ? ONE : mix_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_alpha          <= LOW_ALPHA_RST;
      high_alpha         <= HIGH_ALPHA_RST;
      smooth_coefficient <= SMOOTH_RST;
      mix_amount         <= ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_ALPHA:  low_alpha          <= cfg_data[CW-1:0];
        REG_HIGH_ALPHA: high_alpha         <= cfg_data[CW-1:0];
        REG_SMOOTH:     smooth_coefficient <= cfg_data[CW-1:0];
        REG_MIX:        mix_amount         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bsgd_gain #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_gain (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .target(target_gain),
    .coef  (smooth_coefficient),
    .gain  (gain)
  );

  bsgd_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (left_sample),
    .low_alpha (low_alpha),
    .high_alpha(high_alpha),
    .gain      (gain),
    .mix       (mix_c),
    .done      (lane_done[0]),
    .result    (lane_result[0])
  );

  bsgd_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (right_sample),
    .low_alpha (low_alpha),
    .high_alpha(high_alpha),
    .gain      (gain),
    .mix       (mix_c),
    .done      (lane_done[1]),
    .result    (lane_result[1])
  );

  // merge both lanes and the gain into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (merge) begin
        busy <= 1'b0;
      end
      if (merge) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (merge) begin
      left_out     <= lane_result[0];
      right_out    <= lane_result[1];
      applied_gain <= gain;
    end
  end

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1])
    else $error("channel lanes out of step");

  a_merge_busy: assert property (@(posedge clk) disable iff (rst) merge |-> busy)
    else $error("merge without a request in flight");

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("request taken but block not busy");

endmodule

/* src/bsgd_gain.sv */
`timescale 1ns / 1ps
module bsgd_gain #(
  parameter int COEF_FRAC_BITS = bsgd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COEF_FRAC_BITS:0]   target,
  input  logic [COEF_FRAC_BITS-1:0] coef,
  output logic [COEF_FRAC_BITS:0]   gain
);

  localparam int GBW = COEF_FRAC_BITS + 1;
  localparam int GW  = COEF_FRAC_BITS + 2;
  localparam int PW  = GW + GBW;
  localparam logic [GBW-1:0] ONE = GBW'(1) << COEF_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = signed'(PW'(1) << (COEF_FRAC_BITS - 1));

  logic                  pend;
  logic [GBW-1:0]        tgt;
  logic [GBW-1:0]        tgt_c;
  logic signed [GW-1:0]  gdiff;
  logic signed [GBW-1:0] coef_s;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  prod_rnd;
  logic signed [PW-1:0]  gain_sum;

  assign tgt_c    = (target > ONE) ? ONE : target;
  assign gdiff    = signed'(GW'(gain)) - signed'(GW'(tgt_c));
  assign coef_s   = signed'(GBW'(coef));
  assign prod_rnd = (prod + HALF) >>> COEF_FRAC_BITS;
  assign gain_sum = signed'(PW'(tgt)) + prod_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      gain <= ONE;
    end else begin
      pend <= start;
      if (pend) begin
        gain <= GBW'(gain_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tgt  <= tgt_c;
      prod <= gdiff * coef_s;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst) gain <= ONE)
    else $error("smoothed gain above unity");

endmodule

/* src/bsgd_lane.sv */
`timescale 1ns / 1ps
module bsgd_lane #(
  parameter int SAMPLE_BITS    = bsgd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bsgd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [COEF_FRAC_BITS-1:0]     low_alpha,
  input  logic [COEF_FRAC_BITS-1:0]     high_alpha,
  input  logic [COEF_FRAC_BITS:0]       gain,
  input  logic [COEF_FRAC_BITS:0]       mix,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result
);

  import bsgd_pkg::*;

  localparam int LW = SAMPLE_BITS + COEF_FRAC_BITS + 1;
  localparam int AW = LW + 2;
  localparam int BW = COEF_FRAC_BITS + 2;
  localparam int PW = AW + BW;
  localparam int MW = AW + 1;
  localparam logic signed [PW-1:0] HALF   = signed'(PW'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [MW-1:0] HALF_M = signed'(MW'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [MW-1:0] Y_MAX  = MW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MW-1:0] Y_MIN  = MW'(-(longint'(1) << (SAMPLE_BITS - 1)));

  lane_state_t state;
  lane_state_t state_next;

  logic signed [LW-1:0] xs;
  logic signed [LW-1:0] low;
  logic signed [LW-1:0] high;
  logic signed [AW-1:0] diff;
  logic signed [PW-1:0] prod;

  logic signed [AW-1:0] xs_w;
  logic signed [AW-1:0] low_w;
  logic signed [AW-1:0] high_w;
  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] prod_rnd;
  logic signed [MW-1:0] mixed;
  logic signed [MW-1:0] y_full;

  assign xs_w     = AW'(xs);
  assign low_w    = AW'(low);
  assign high_w   = AW'(high);
  assign prod_rnd = (prod + HALF) >>> COEF_FRAC_BITS;
  assign mixed    = MW'(xs) + MW'(prod_rnd);
  assign y_full   = (mixed + HALF_M) >>> COEF_FRAC_BITS;
  assign done     = (state == ST_DONE);

  // one multiplier per lane, operands picked by step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_LOW_MUL: begin
        op_a = xs_w - low_w;
        op_b = signed'(BW'(low_alpha));
      end
      ST_HIGH_MUL: begin
        op_a = xs_w - high_w;
        op_b = signed'(BW'(high_alpha));
      end
      ST_BAND_MUL: begin
        op_a = high_w - low_w;
        op_b = signed'(BW'(gain));
      end
      ST_MIX_MUL: begin
        op_a = diff;
        op_b = signed'(BW'(mix));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_LOW_MUL;
      ST_LOW_MUL:  state_next = ST_LOW_ADD;
      ST_LOW_ADD:  state_next = ST_HIGH_MUL;
      ST_HIGH_MUL: state_next = ST_HIGH_ADD;
      ST_HIGH_ADD: state_next = ST_BAND_MUL;
      ST_BAND_MUL: state_next = ST_BAND_ADD;
      ST_BAND_ADD: state_next = ST_MIX_MUL;
      ST_MIX_MUL:  state_next = ST_MIX_ADD;
      ST_MIX_ADD:  state_next = ST_DONE;
      ST_DONE:     if (start) state_next = ST_LOW_MUL;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      low   <= '0;
      high  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOW_ADD) begin
        low <= low + LW'(prod_rnd);
      end
      if (state == ST_HIGH_ADD) begin
        high <= high + LW'(prod_rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == ST_IDLE || state == ST_DONE)) begin
      xs <= {sample[SAMPLE_BITS-1], sample, {COEF_FRAC_BITS{1'b0}}};
    end
    prod <= op_a * op_b;
    if (state == ST_BAND_ADD) begin
      diff <= low_w - high_w + AW'(prod_rnd);
    end
    if (state == ST_MIX_ADD) begin
      if (y_full > Y_MAX) begin
        result <= SAMPLE_BITS'(Y_MAX);
      end else if (y_full < Y_MIN) begin
        result <= SAMPLE_BITS'(Y_MIN);
      end else begin
        result <= SAMPLE_BITS'(y_full);
      end
    end
  end

endmodule
